/* sv/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* sv/scs1_pkg.sv */
// package with scan code constants, key table and decode types
`timescale 1ns / 1ps
`default_nettype none

package scs1_pkg;

    localparam logic [7:0] C_PREFIX    = 8'hE0;
    localparam logic [6:0] C_LSHIFT    = 7'h2A;
    localparam logic [6:0] C_RSHIFT    = 7'h36;
    localparam logic [6:0] C_CAPS_LOCK = 7'h3A;

    typedef struct packed {
        logic       emit;
        logic [6:0] char_code;
    } t_dec;

    // us layout, unshifted
    function automatic logic [6:0] key_lookup(input logic [6:0] idx);
        logic [6:0] c;
        unique case (idx)
            7'd1:    c = 7'h1B;
            7'd2:    c = 7'h31;
            7'd3:    c = 7'h32;
            7'd4:    c = 7'h33;
            7'd5:    c = 7'h34;
            7'd6:    c = 7'h35;
            7'd7:    c = 7'h36;
            7'd8:    c = 7'h37;
            7'd9:    c = 7'h38;
            7'd10:   c = 7'h39;
            7'd11:   c = 7'h30;
            7'd12:   c = 7'h2D;
            7'd13:   c = 7'h3D;
            7'd14:   c = 7'h08;
            7'd15:   c = 7'h09;
            7'd16:   c = 7'h71;
            7'd17:   c = 7'h77;
            7'd18:   c = 7'h65;
            7'd19:   c = 7'h72;
            7'd20:   c = 7'h74;
            7'd21:   c = 7'h79;
            7'd22:   c = 7'h75;
            7'd23:   c = 7'h69;
            7'd24:   c = 7'h6F;
            7'd25:   c = 7'h70;
            7'd26:   c = 7'h5B;
            7'd27:   c = 7'h5D;
            7'd28:   c = 7'h0A;
            7'd30:   c = 7'h61;
            7'd31:   c = 7'h73;
            7'd32:   c = 7'h64;
            7'd33:   c = 7'h66;
            7'd34:   c = 7'h67;
            7'd35:   c = 7'h68;
            7'd36:   c = 7'h6A;
            7'd37:   c = 7'h6B;
            7'd38:   c = 7'h6C;
            7'd39:   c = 7'h3B;
            7'd40:   c = 7'h27;
            7'd41:   c = 7'h60;
            7'd43:   c = 7'h5C;
            7'd44:   c = 7'h7A;
            7'd45:   c = 7'h78;
            7'd46:   c = 7'h63;
            7'd47:   c = 7'h76;
            7'd48:   c = 7'h62;
            7'd49:   c = 7'h6E;
            7'd50:   c = 7'h6D;
            7'd51:   c = 7'h2C;
            7'd52:   c = 7'h2E;
            7'd53:   c = 7'h2F;
            7'd55:   c = 7'h2A;
            7'd57:   c = 7'h20;
            7'd74:   c = 7'h2D;
            7'd78:   c = 7'h2B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shifted_symbol(input logic [6:0] c);
        logic [6:0] s;
        unique case (c)
            7'h31:   s = 7'h21;
            7'h32:   s = 7'h40;
            7'h33:   s = 7'h23;
            7'h34:   s = 7'h24;
            7'h35:   s = 7'h25;
            7'h36:   s = 7'h5E;
            7'h37:   s = 7'h26;
            7'h38:   s = 7'h2A;
            7'h39:   s = 7'h28;
            7'h30:   s = 7'h29;
            7'h2D:   s = 7'h5F;
            7'h3D:   s = 7'h2B;
            7'h5B:   s = 7'h7B;
            7'h5D:   s = 7'h7D;
            7'h5C:   s = 7'h7C;
            7'h3B:   s = 7'h3A;
            7'h27:   s = 7'h22;
            7'h2C:   s = 7'h3C;
            7'h2E:   s = 7'h3E;
            7'h2F:   s = 7'h3F;
            7'h60:   s = 7'h7E;
            default: s = c;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/scs1_in_reg.sv */
// input register for scan bytes
`timescale 1ns / 1ps
`default_nettype none

module scs1_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_scan_byte,
    input  wire logic       i_take,
    output logic            o_vld,
    output logic [7:0]      o_byte
);
    import scs1_pkg::*;

    logic       r_vld;
    logic       n_vld;
    logic [7:0] r_byte;
    logic       w_load;

    assign o_ready = !r_vld || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        if (w_load) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_scan_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

`default_nettype wire

/* sv/scs1_decode.sv */
// key flags and scan code to character decode
`timescale 1ns / 1ps
`default_nettype none

module scs1_decode (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_fire,
    output scs1_pkg::t_dec  o_dec
);
    import scs1_pkg::*;

    logic       r_shift;
    logic       r_caps;
    logic       r_pfx;
    logic       n_shift;
    logic       n_caps;
    logic       n_pfx;
    logic [6:0] w_low;
    logic       w_shift_code;
    logic [6:0] w_base;
    logic [6:0] w_char;
    logic       w_letter;

    assign w_low        = i_byte[6:0];
    assign w_shift_code = (w_low == C_LSHIFT) || (w_low == C_RSHIFT);
    assign w_base       = key_lookup(w_low);
    assign w_letter     = (w_base >= 7'h61) && (w_base <= 7'h7A);

    always_comb begin
        if (w_letter) begin
            w_char = (r_shift ^ r_caps) ? (w_base - 7'h20) : w_base;
        end else if (r_shift) begin
            w_char = shifted_symbol(w_base);
        end else begin
            w_char = w_base;
        end
    end

    always_comb begin
        n_shift         = r_shift;
        n_caps          = r_caps;
        n_pfx           = r_pfx;
        o_dec.emit      = 1'b0;
        o_dec.char_code = w_char;
        if (i_byte == C_PREFIX) begin
            n_pfx = 1'b1;
        end else if (i_byte[7]) begin
            // break code
            if (w_shift_code) begin
                n_shift = 1'b0;
            end
            n_pfx = 1'b0;
        end else if (w_shift_code) begin
            n_shift = 1'b1;
        end else if (w_low == C_CAPS_LOCK) begin
            n_caps = !r_caps;
        end else if (r_pfx) begin
            n_pfx = 1'b0;
        end else begin
            o_dec.emit = (w_char != 7'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_pfx   <= 1'b0;
        end else if (i_fire) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_pfx   <= n_pfx;
        end
    end

endmodule

`default_nettype wire

/* sv/scs1_out_reg.sv */
// result register for decoded characters
`timescale 1ns / 1ps
`default_nettype none

module scs1_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [6:0] i_char,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [6:0]      o_char_code
);
    import scs1_pkg::*;

    logic       r_vld;
    logic       n_vld;
    logic [6:0] r_char;

    assign o_free = !r_vld || i_ready;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_char;
        end
    end

    assign o_valid     = r_vld;
    assign o_char_code = r_char;

endmodule

`default_nettype wire

/* sv/scancode_set1_to_ascii.sv */
// top level of the set 1 scan code to ascii translator
//
// channel   direction  handshake            payload
// scan in   input      i_valid / o_ready    i_scan_byte[7:0]
// char out  output     o_valid / i_ready    o_char_code[6:0]
//
// one byte per cycle unless stalled; a character shows the cycle after its byte is taken
// decode is one table lookup plus flag update between the input and result registers
// synchronous active-low reset clears the valids and the shift, caps and prefix flags
// a stalled output holds a byte in the input register only when it would emit a character
// bytes that give no character keep flowing while the output is stalled
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scancode_set1_to_ascii (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_scan_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [6:0]      o_char_code
);
    import scs1_pkg::*;

    logic       w_in_vld;
    logic [7:0] w_in_byte;
    logic       w_take;
    logic       w_load;
    logic       w_out_free;
    logic       w_blocked;
    t_dec       w_dec;

    assign w_take    = w_in_vld && (!w_dec.emit || w_out_free);
    assign w_load    = w_take && w_dec.emit;
    assign w_blocked = w_in_vld && w_dec.emit && !w_out_free;

    scs1_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_scan_byte (i_scan_byte),
        .i_take      (w_take),
        .o_vld       (w_in_vld),
        .o_byte      (w_in_byte)
    );

    scs1_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (w_in_byte),
        .i_fire  (w_take),
        .o_dec   (w_dec)
    );

    scs1_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_char      (w_dec.char_code),
        .o_free      (w_out_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code)
    );

    `ASSERT_NEVER(a_no_zero_char, o_valid && (o_char_code == 7'h00), "null character on output")
    `ASSERT_NEVER(a_no_overwrite, w_load && o_valid && !i_ready, "result register overwritten")
    `ASSERT_CLK(a_blocked_stall, w_blocked |-> !o_ready, "input taken while blocked")
    `ASSERT_CLK(a_emit_shows, w_load |=> o_valid, "emitted character not presented")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the set 1 scan code to ascii translator
`timescale 1ns / 1ps

module testbench;

    import scs1_pkg::*;

    class char_scoreboard;
        logic [6:0] expected_chars[$];
        bit         shift_held;
        bit         caps_on;
        bit         prefix_pending;
        int         mismatches;
        int         chars_checked;
        int         bytes_taken;

        function new();
            expected_chars.delete();
            shift_held     = 1'b0;
            caps_on        = 1'b0;
            prefix_pending = 1'b0;
            mismatches     = 0;
            chars_checked  = 0;
            bytes_taken    = 0;
        endfunction

        // us layout, unshifted
        function logic [7:0] us_key(input logic [6:0] idx);
            logic [7:0] c;
            case (idx)
                7'h01: c = 8'h1B;
                7'h02: c = "1";
                7'h03: c = "2";
                7'h04: c = "3";
                7'h05: c = "4";
                7'h06: c = "5";
                7'h07: c = "6";
                7'h08: c = "7";
                7'h09: c = "8";
                7'h0A: c = "9";
                7'h0B: c = "0";
                7'h0C: c = "-";
                7'h0D: c = "=";
                7'h0E: c = 8'h08;
                7'h0F: c = 8'h09;
                7'h10: c = "q";
                7'h11: c = "w";
                7'h12: c = "e";
                7'h13: c = "r";
                7'h14: c = "t";
                7'h15: c = "y";
                7'h16: c = "u";
                7'h17: c = "i";
                7'h18: c = "o";
                7'h19: c = "p";
                7'h1A: c = "[";
                7'h1B: c = "]";
                7'h1C: c = 8'h0A;
                7'h1E: c = "a";
                7'h1F: c = "s";
                7'h20: c = "d";
                7'h21: c = "f";
                7'h22: c = "g";
                7'h23: c = "h";
                7'h24: c = "j";
                7'h25: c = "k";
                7'h26: c = "l";
                7'h27: c = ";";
                7'h28: c = 8'h27;
                7'h29: c = 8'h60;
                7'h2B: c = 8'h5C;
                7'h2C: c = "z";
                7'h2D: c = "x";
                7'h2E: c = "c";
                7'h2F: c = "v";
                7'h30: c = "b";
                7'h31: c = "n";
                7'h32: c = "m";
                7'h33: c = ",";
                7'h34: c = ".";
                7'h35: c = "/";
                7'h37: c = "*";
                7'h39: c = " ";
                7'h4A: c = "-";
                7'h4E: c = "+";
                default: c = 8'h00;
            endcase
            return c;
        endfunction

        function logic [7:0] shifted_form(input logic [7:0] c);
            logic [7:0] s;
            case (c)
                "1":   s = "!";
                "2":   s = "@";
                "3":   s = "#";
                "4":   s = "$";
                "5":   s = "%";
                "6":   s = "^";
                "7":   s = "&";
                "8":   s = "*";
                "9":   s = "(";
                "0":   s = ")";
                "-":   s = "_";
                "=":   s = "+";
                "[":   s = "{";
                "]":   s = "}";
                8'h5C: s = "|";
                ";":   s = ":";
                8'h27: s = 8'h22;
                ",":   s = "<";
                ".":   s = ">";
                "/":   s = "?";
                8'h60: s = 8'h7E;
                default: s = c;
            endcase
            return s;
        endfunction

        function void note_scan(input logic [7:0] code);
            logic [7:0] c;
            bytes_taken++;
            if (code == C_PREFIX) begin
                prefix_pending = 1'b1;
            end else if (code[7]) begin
                if (code[6:0] == C_LSHIFT || code[6:0] == C_RSHIFT) begin
                    shift_held = 1'b0;
                end
                prefix_pending = 1'b0;
            end else if (code[6:0] == C_LSHIFT || code[6:0] == C_RSHIFT) begin
                shift_held = 1'b1;
            end else if (code[6:0] == C_CAPS_LOCK) begin
                caps_on = !caps_on;
            end else if (prefix_pending) begin
                prefix_pending = 1'b0;
            end else begin
                c = us_key(code[6:0]);
                if (c >= "a" && c <= "z") begin
                    if (shift_held != caps_on) begin
                        c = c - 8'h20;
                    end
                end else if (shift_held) begin
                    c = shifted_form(c);
                end
                if (c != 8'h00) begin
                    expected_chars.push_back(c[6:0]);
                end
            end
        endfunction

        function void check_char(input logic [6:0] got);
            logic [6:0] want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected char_code, expected none, actual %h", $time, got);
                return;
            end
            want = expected_chars.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: char_code mismatch, expected %h, actual %h", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_scan_byte;
    logic       o_valid;
    logic       i_ready;
    logic [6:0] o_char_code;

    char_scoreboard sb;
    int             idle_odds;
    bit             drain_done;

    scancode_set1_to_ascii u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_scan_byte (i_scan_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver back-pressure in random bursts
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_char(o_char_code);
        end
    end

    task automatic send_scan(input logic [7:0] code, input bit drain);
        int gap;
        gap = 0;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (drain && gap == 0) begin
            gap = 1;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            if (drain) begin
                while (sb.pending() != 0) @(negedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_scan_byte <= code;
        do @(posedge i_clk); while (!o_ready);
        sb.note_scan(code);
    endtask

    function automatic logic [7:0] random_scan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(1, 8'h39));
        if (r < 52) begin
            case ($urandom_range(0, 2))
                0:       return 8'h4A;
                1:       return 8'h4E;
                default: return 8'h37;
            endcase
        end
        if (r < 60) return $urandom_range(0, 1) ? {1'b0, C_LSHIFT} : {1'b0, C_RSHIFT};
        if (r < 68) return $urandom_range(0, 1) ? {1'b1, C_LSHIFT} : {1'b1, C_RSHIFT};
        if (r < 72) return {1'b0, C_CAPS_LOCK};
        if (r < 80) return C_PREFIX;
        if (r < 90) return 8'h80 | 8'($urandom_range(1, 8'h58));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] directed[$];
        sb              = new();
        idle_odds       = 4;
        drain_done      = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_scan_byte     = 8'h00;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{8'h00, 8'h1E, 8'h36, 8'h1E, 8'h02, 8'h4A, 8'h0C, 8'h3A,
                     8'h1E, 8'hAA, 8'h1E, 8'h02, 8'hE0, 8'h2A, 8'h1C, 8'hB6,
                     8'hE0, 8'h3A, 8'h9C, 8'h1C, 8'h7F, 8'h80, 8'hFF, 8'h39,
                     8'hE0, 8'h4A, 8'h01};
        foreach (directed[k]) begin
            send_scan(directed[k], 1'b0);
        end

        while (sb.bytes_taken < 650) begin
            if (sb.bytes_taken < 200) begin
                idle_odds = 3;
            end else if (sb.bytes_taken < 300) begin
                idle_odds = 0;
            end else if (sb.bytes_taken < 550) begin
                idle_odds = 2;
            end else begin
                idle_odds = 0;
            end
            if (!drain_done && sb.bytes_taken >= 350) begin
                drain_done = 1'b1;
                send_scan(random_scan(), 1'b1);
            end else begin
                send_scan(random_scan(), 1'b0);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d scan bytes and %0d characters, with shift, caps and prefix",
                 sb.bytes_taken, sb.chars_checked);
        $display("%0d mismatches, %0d characters still outstanding", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/scs1_pkg.sv
sv/scs1_in_reg.sv
sv/scs1_decode.sv
sv/scs1_out_reg.sv
sv/scancode_set1_to_ascii.sv
verif/testbench.sv
